// ----- hdl/kbs_pkg.sv -----
package kbs_pkg;

  localparam int StampW   = 32;
  localparam int DistW    = 52;
  localparam int TimeoutW = 32;
  localparam int BatchW   = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 52;

  localparam logic [DistW-1:0]    DistMax     = {DistW{1'b1}};
  localparam logic [TimeoutW-1:0] TimeoutRst  = 32'd5000;
  localparam logic [BatchW-1:0]   BatchRst    = 5'd5;

  localparam logic [CfgIdxW-1:0] CFG_DIST_THR_SQ   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STALE_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BATCH_SIZE    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_DECIDE = 5'b10000
  } kbs_state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic commit;
  } kbs_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_idle;
    logic out_free;
  } kbs_stat_t;

endpackage

// ----- hdl/kbs_in_if.sv -----
interface kbs_in_if #(
  parameter int PosWidth = 24
) ();
  logic                             valid;
  logic                             ready;
  logic signed [PosWidth-1:0]       pos_x;
  logic signed [PosWidth-1:0]       pos_y;
  logic signed [PosWidth-1:0]       pos_z;
  logic [kbs_pkg::StampW-1:0]       stamp_ms;

  modport source (output valid, pos_x, pos_y, pos_z, stamp_ms, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, stamp_ms, output ready);
endinterface

// ----- hdl/kbs_out_if.sv -----
interface kbs_out_if #(
  parameter int SlotWidth = 4
) ();
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [SlotWidth-1:0]        slot;
  logic                        batch_done;
  logic [kbs_pkg::DistW-1:0]   min_dist_sq;
  logic                        was_stale;

  modport source (output valid, accepted, slot, batch_done, min_dist_sq, was_stale,
                  input ready);
  modport sink   (input valid, accepted, slot, batch_done, min_dist_sq, was_stale,
                  output ready);
endinterface

// ----- hdl/kbs_ctrl.sv -----
module kbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kbs_pkg::kbs_stat_t stat_i,
  output kbs_pkg::kbs_cmd_t  cmd_o
);

  kbs_pkg::kbs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kbs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      kbs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = kbs_pkg::S_CHECK;
        end
      end
      kbs_pkg::S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = kbs_pkg::S_SCAN;
      end
      kbs_pkg::S_SCAN: begin
        if (stat_i.count_zero) begin
          state_d = kbs_pkg::S_DECIDE;
        end else begin
          cmd_o.scan = 1'b1;
          if (stat_i.scan_last) begin
            state_d = kbs_pkg::S_DRAIN;
          end
        end
      end
      kbs_pkg::S_DRAIN: begin
        if (stat_i.pipe_idle) begin
          state_d = kbs_pkg::S_DECIDE;
        end
      end
      kbs_pkg::S_DECIDE: begin
        // hold until the result register can take the transfer
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = kbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kbs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/kbs_datapath.sv -----
module kbs_datapath #(
  parameter int MAX_VIEWS = 16,
  parameter int POS_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kbs_pkg::kbs_cmd_t               cmd_i,
  output kbs_pkg::kbs_stat_t              stat_o,
  input  logic [POS_WIDTH-1:0]            pos_x_i,
  input  logic [POS_WIDTH-1:0]            pos_y_i,
  input  logic [POS_WIDTH-1:0]            pos_z_i,
  input  logic [kbs_pkg::StampW-1:0]      stamp_ms_i,
  input  logic                            cfg_we_i,
  input  logic [kbs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [kbs_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output logic                            res_accepted_o,
  output logic [$clog2(MAX_VIEWS)-1:0]    res_slot_o,
  output logic                            res_batch_done_o,
  output logic [kbs_pkg::DistW-1:0]       res_min_dist_sq_o,
  output logic                            res_was_stale_o
);

  localparam int IdxW  = $clog2(MAX_VIEWS);
  localparam int CntW  = $clog2(MAX_VIEWS + 1);
  localparam int SqW   = 2 * POS_WIDTH;
  localparam int SumW  = SqW + 2;
  localparam int ExtW  = (SumW > kbs_pkg::DistW) ? SumW : kbs_pkg::DistW;
  localparam int AgeW  = kbs_pkg::StampW + 2;

  // configuration
  logic [kbs_pkg::DistW-1:0]    thr_q;
  logic [kbs_pkg::TimeoutW-1:0] timeout_q;
  logic [kbs_pkg::BatchW-1:0]   batch_q;

  // frame under work
  logic [POS_WIDTH-1:0]         pos_q [3];
  logic [kbs_pkg::StampW-1:0]   stamp_q;
  logic                         stale_q;

  // keyframe set
  logic [POS_WIDTH-1:0]         key_pos_mem [MAX_VIEWS][3];
  logic [CntW-1:0]              count_q;
  logic [kbs_pkg::StampW-1:0]   ref_time_q;
  logic [IdxW-1:0]              scan_idx_q;

  // distance pipeline
  logic [3:0]                   pipe_v_q;
  logic [POS_WIDTH-1:0]         rd_q  [3];
  logic [POS_WIDTH-1:0]         adx_q [3];
  logic [POS_WIDTH-1:0]         adx_d [3];
  logic [SqW-1:0]               sq_q  [3];
  logic [ExtW-1:0]              sum_d;
  logic [kbs_pkg::DistW-1:0]    dist_d, dist_q;
  logic [kbs_pkg::DistW-1:0]    min_q;

  // decision
  logic signed [AgeW-1:0]       age_d;
  logic                         stale_d;
  logic [CntW-1:0]              batch_eff_d;
  logic [CntW:0]                cnt_inc_d;
  logic                         accept_d;
  logic                         done_d;
  logic                         ref_upd_d;
  logic                         count_zero;

  // result register
  logic                         res_valid_q;
  logic                         res_accepted_q;
  logic [IdxW-1:0]              res_slot_q;
  logic                         res_batch_done_q;
  logic [kbs_pkg::DistW-1:0]    res_min_dist_sq_q;
  logic                         res_was_stale_q;

  assign count_zero = (count_q == '0);

  assign age_d   = $signed({2'b00, stamp_q}) - $signed({2'b00, ref_time_q});
  assign stale_d = age_d > $signed({2'b00, timeout_q});

  always_comb begin
    if (batch_q == '0) begin
      batch_eff_d = CntW'(1);
    end else if (int'(batch_q) > MAX_VIEWS) begin
      batch_eff_d = CntW'(MAX_VIEWS);
    end else begin
      batch_eff_d = CntW'(batch_q);
    end
  end

  assign cnt_inc_d = {1'b0, count_q} + (CntW + 1)'(1);
  assign accept_d  = count_zero || (min_q > thr_q);
  assign done_d    = accept_d && (cnt_inc_d >= {1'b0, batch_eff_d});
  assign ref_upd_d = count_q <= (batch_eff_d >> 1);

  assign stat_o.count_zero = count_zero;
  assign stat_o.scan_last  = (CntW'(scan_idx_q) + CntW'(1)) == count_q;
  assign stat_o.pipe_idle  = (pipe_v_q == '0);
  assign stat_o.out_free   = !res_valid_q || res_ready_i;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [POS_WIDTH:0] pe;
    logic signed [POS_WIDTH:0] re;
    assign pe = {pos_q[a][POS_WIDTH-1], pos_q[a]};
    assign re = {rd_q[a][POS_WIDTH-1], rd_q[a]};
    assign adx_d[a] = (pe >= re) ? POS_WIDTH'(pe - re) : POS_WIDTH'(re - pe);

    always_ff @(posedge clk_i) begin
      adx_q[a] <= adx_d[a];
      sq_q[a]  <= SqW'(adx_q[a]) * SqW'(adx_q[a]);
    end
  end

  assign sum_d  = ExtW'(sq_q[0]) + ExtW'(sq_q[1]) + ExtW'(sq_q[2]);
  assign dist_d = (sum_d > ExtW'(kbs_pkg::DistMax)) ? kbs_pkg::DistMax
                                                    : sum_d[kbs_pkg::DistW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      timeout_q   <= kbs_pkg::TimeoutRst;
      batch_q     <= kbs_pkg::BatchRst;
      count_q     <= '0;
      ref_time_q  <= '0;
      pipe_v_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kbs_pkg::CFG_DIST_THR_SQ:   thr_q     <= cfg_data_i;
          kbs_pkg::CFG_STALE_TIMEOUT: timeout_q <= cfg_data_i[kbs_pkg::TimeoutW-1:0];
          kbs_pkg::CFG_BATCH_SIZE:    batch_q   <= cfg_data_i[kbs_pkg::BatchW-1:0];
          default: ;
        endcase
      end

      pipe_v_q <= {pipe_v_q[2:0], cmd_i.scan};

      // drop the stored set on timeout
      if (cmd_i.check && stale_d) begin
        count_q <= '0;
      end

      if (cmd_i.commit && accept_d) begin
        if (ref_upd_d) begin
          ref_time_q <= stamp_q;
        end
        count_q <= done_d ? '0 : cnt_inc_d[CntW-1:0];
      end

      if (cmd_i.commit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      stamp_q  <= stamp_ms_i;
    end

    if (cmd_i.check) begin
      stale_q    <= stale_d;
      scan_idx_q <= '0;
      min_q      <= kbs_pkg::DistMax;
    end else begin
      if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + IdxW'(1);
      end
      if (pipe_v_q[3] && (dist_q < min_q)) begin
        min_q <= dist_q;
      end
    end

    if (cmd_i.scan) begin
      rd_q <= key_pos_mem[scan_idx_q];
    end
    dist_q <= dist_d;

    if (cmd_i.commit && accept_d) begin
      key_pos_mem[count_q[IdxW-1:0]] <= pos_q;
    end

    if (cmd_i.commit) begin
      res_accepted_q    <= accept_d;
      res_slot_q        <= accept_d ? count_q[IdxW-1:0] : '0;
      res_batch_done_q  <= done_d;
      res_min_dist_sq_q <= count_zero ? '0 : min_q;
      res_was_stale_q   <= stale_q;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_accepted_o    = res_accepted_q;
  assign res_slot_o        = res_slot_q;
  assign res_batch_done_o  = res_batch_done_q;
  assign res_min_dist_sq_o = res_min_dist_sq_q;
  assign res_was_stale_o   = res_was_stale_q;

endmodule

// ----- hdl/keyframe_baseline_selector.sv -----
// A frame is loaded, checked for timeout, scanned against the stored keyframes, drained
// and decided before its result is registered; an empty set skips scan and drain. One
// stored position per cycle goes through a distance pipeline (read, absolute difference,
// square and saturating sum registers) fed from the keyframe memory's read port. A new
// frame is taken only in idle, once the last result is committed, and may transfer while
// that result waits in the output register. Reset clears the keyframe count, reference
// time, result valid and loads the register defaults; stored positions are not cleared.
module keyframe_baseline_selector #(
  parameter int MAX_VIEWS = 16,
  parameter int POS_WIDTH = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  kbs_in_if.sink                       frame_i,
  kbs_out_if.source                    result_o,
  input  logic                         cfg_we_i,
  input  logic [kbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kbs_pkg::CfgDataW-1:0] cfg_data_i
);

  kbs_pkg::kbs_cmd_t  cmd;
  kbs_pkg::kbs_stat_t stat;

  kbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_ready_o (frame_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kbs_datapath #(
    .MAX_VIEWS (MAX_VIEWS),
    .POS_WIDTH (POS_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .pos_x_i           (frame_i.pos_x),
    .pos_y_i           (frame_i.pos_y),
    .pos_z_i           (frame_i.pos_z),
    .stamp_ms_i        (frame_i.stamp_ms),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .res_ready_i       (result_o.ready),
    .res_valid_o       (result_o.valid),
    .res_accepted_o    (result_o.accepted),
    .res_slot_o        (result_o.slot),
    .res_batch_done_o  (result_o.batch_done),
    .res_min_dist_sq_o (result_o.min_dist_sq),
    .res_was_stale_o   (result_o.was_stale)
  );

endmodule

// ----- hdl/kbs_checker.sv -----
module kbs_checker #(
  parameter int SlotW = 4
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      accepted_i,
  input logic [SlotW-1:0]          slot_i,
  input logic                      batch_done_i,
  input logic [kbs_pkg::DistW-1:0] min_dist_sq_i,
  input logic                      was_stale_i
);

  // a rejected frame was stored nowhere and closed no batch
  a_reject_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !accepted_i) |-> (slot_i == '0 && !batch_done_i))
    else $error("rejected frame reports a slot or batch completion");

  // a timeout empties the set, so the frame must be stored
  a_stale_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && was_stale_i) |-> accepted_i)
    else $error("stale frame was not accepted");

  // one frame at a time: no second transfer right behind the first
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(accepted_i) && $stable(slot_i) && $stable(batch_done_i)
       && $stable(min_dist_sq_i) && $stable(was_stale_i)))
    else $error("stalled result changed");

endmodule

bind keyframe_baseline_selector kbs_checker #(
  .SlotW ($clog2(MAX_VIEWS))
) u_kbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (frame_i.valid),
  .in_ready_i    (frame_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .accepted_i    (result_o.accepted),
  .slot_i        (result_o.slot),
  .batch_done_i  (result_o.batch_done),
  .min_dist_sq_i (result_o.min_dist_sq),
  .was_stale_i   (result_o.was_stale)
);
